/* rtl/pvs_pkg.sv */
// ----------------------------------------------------------------------------
// pvs_pkg: shared types and constants for the page victim selector
// Field widths, request and register codes, controller states, and the
// control groups that travel along the cell chain.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int REQ_W       = 2;
  localparam int REF_INDEX_W = 10;
  localparam int PAGE_W      = 16;
  localparam int FRAME_W     = 3;
  localparam int VICTIM_W    = 3;
  localparam int SEQ_LEN_W   = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  // Stream word layouts, padded to whole bytes.
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_SELECT  = 2'd2,
    REQ_RECORD  = 2'd3
  } req_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POLICY  = 1'd0,
    CFG_SEQ_LEN = 1'd1
  } cfg_reg_t;

  typedef enum logic {
    POLICY_FIFO    = 1'b0,
    POLICY_OPTIMAL = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  // Framing of one reference word moving down the cell chain.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } word_ctl_t;

  // Status of the victim search token that rides on the last word.
  typedef struct packed {
    logic done;   // some frame never recurs, search is settled
    logic have;   // a farthest-use candidate has been taken
  } token_t;

endpackage

/* rtl/pvs_ram.sv */
// ----------------------------------------------------------------------------
// pvs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module pvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pvs_cell.sv */
// ----------------------------------------------------------------------------
// pvs_cell: one frame of the victim search chain
// Holds the page resident in its frame, records the first position at which
// that page recurs in the passing reference words, and folds its verdict
// into the search token when the last word of a scan goes by.
// ----------------------------------------------------------------------------
module pvs_cell #(
  parameter int FW      = 3,
  parameter int PW      = 10,
  parameter int CELL_ID = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      page_we,
  input  logic [pvs_pkg::PAGE_W-1:0] page_wdata,
  input  pvs_pkg::word_ctl_t        in_ctl,
  input  logic [pvs_pkg::PAGE_W-1:0] in_page,
  input  logic [PW-1:0]             in_pos,
  input  pvs_pkg::token_t           in_tok,
  input  logic [FW-1:0]             in_best,
  input  logic [PW-1:0]             in_best_pos,
  output pvs_pkg::word_ctl_t        out_ctl,
  output logic [pvs_pkg::PAGE_W-1:0] out_page,
  output logic [PW-1:0]             out_pos,
  output pvs_pkg::token_t           out_tok,
  output logic [FW-1:0]             out_best,
  output logic [PW-1:0]             out_best_pos
);

  import pvs_pkg::*;

  logic [PAGE_W-1:0] frame_page;
  logic              found;
  logic [PW-1:0]     found_pos;

  logic              seen;
  logic              match;
  logic              found_next;
  logic [PW-1:0]     found_pos_next;
  token_t            tok_next;
  logic [FW-1:0]     best_next;
  logic [PW-1:0]     best_pos_next;

  // A first word starts a fresh scan, so earlier hits are forgotten.
  always_comb begin
    seen           = found & ~in_ctl.first;
    match          = in_ctl.valid && (in_page == frame_page);
    found_next     = seen | match;
    found_pos_next = seen ? found_pos : in_pos;
  end

  // Lowest frame that never recurs wins outright; otherwise the strictly
  // farthest next use wins, so ties stay with the lower frame.
  always_comb begin
    tok_next      = in_tok;
    best_next     = in_best;
    best_pos_next = in_best_pos;
    if (!in_tok.done) begin
      if (!found_next) begin
        tok_next.done = 1'b1;
        best_next     = FW'(CELL_ID);
      end else if (!in_tok.have || (found_pos_next > in_best_pos)) begin
        tok_next.have = 1'b1;
        best_next     = FW'(CELL_ID);
        best_pos_next = found_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_page <= '0;
      found      <= 1'b0;
      out_ctl    <= '0;
    end else begin
      if (page_we) begin
        frame_page <= page_wdata;
      end
      if (in_ctl.valid) begin
        found <= found_next;
      end
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      found_pos <= found_pos_next;
    end
    out_page     <= in_page;
    out_pos      <= in_pos;
    out_tok      <= tok_next;
    out_best     <= best_next;
    out_best_pos <= best_pos_next;
  end

endmodule

/* rtl/page_victim_selector_unit.sv */
// ----------------------------------------------------------------------------
// page_victim_selector_unit: FIFO and farthest-next-use page victim selector
// Loads a reference string, tracks the page held in each frame, and answers
// select requests with the frame to evict.
// ----------------------------------------------------------------------------
// Results: load, restart, record and free/FIFO selects register their word
//   in the output register or skid slot on acceptance, and so does an optimal
//   select with no reference entries left to look at. Any other optimal select
//   scans the N reference entries from the future pointer to the end of
//   the string (at most SEQ_DEPTH), answering once the last leaves the chain.
// Throughput: one item at a time; an optimal select reads one reference
//   entry per cycle through the single RAM read port, then drains the chain.
// Reset: clears policy, length, pointers, counts and frame pages; the
//   reference RAM is not cleared and must be loaded before it is scanned.
// ----------------------------------------------------------------------------
module page_victim_selector_unit #(
  parameter int FRAME_COUNT = 8,
  parameter int SEQ_DEPTH   = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // Slave stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata, from bit 0: ref_index[9:0], page[25:10], frame[28:26], zero pad
  input  logic [pvs_pkg::S_TDATA_W-1:0]     s_tdata,
  // tuser: req_type[1:0]
  input  logic [pvs_pkg::S_TUSER_W-1:0]     s_tuser,
  // Master stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata, from bit 0: victim[2:0], from_free[3], zero pad
  output logic [pvs_pkg::M_TDATA_W-1:0]     m_tdata,
  // tuser: victim_valid[0]
  output logic [pvs_pkg::M_TUSER_W-1:0]     m_tuser,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [pvs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pvs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pvs_pkg::*;

  // Frame index, free count, RAM address and future pointer widths. The
  // wider compare widths let fixed-width fields be range checked against
  // either parameter without losing bits.
  localparam int FW  = $clog2(FRAME_COUNT);
  localparam int FCW = $clog2(FRAME_COUNT + 1);
  localparam int AW  = $clog2(SEQ_DEPTH);
  localparam int FPW = $clog2(SEQ_DEPTH + 1);
  localparam int EW  = (FPW > SEQ_LEN_W) ? FPW : SEQ_LEN_W;
  localparam int IW  = (FPW > REF_INDEX_W) ? FPW : REF_INDEX_W;
  localparam int CW  = (FCW > FRAME_W) ? FCW : FRAME_W;

  // Input word fields.
  req_t                   req;
  logic [REF_INDEX_W-1:0] in_ref_index;
  logic [PAGE_W-1:0]      in_page;
  logic [FRAME_W-1:0]     in_frame;

  assign req          = req_t'(s_tuser[REQ_W-1:0]);
  assign in_ref_index = s_tdata[REF_INDEX_W-1:0];
  assign in_page      = s_tdata[REF_INDEX_W +: PAGE_W];
  assign in_frame     = s_tdata[REF_INDEX_W + PAGE_W +: FRAME_W];

  // Configuration registers.
  policy_t             policy;
  logic [SEQ_LEN_W-1:0] seq_len;

  // Replacement state.
  logic [FW-1:0]  fifo_ptr;
  logic [FCW-1:0] free_cnt;
  logic [FPW-1:0] fut_ptr;

  // Scan control.
  state_t         state;
  state_t         state_next;
  logic [FPW-1:0] rd_cnt;
  logic [FPW-1:0] end_ptr;
  logic [EW-1:0]  len_ext;
  logic           rd_en;
  logic           rd_last;
  logic           scan_empty;
  logic           free_full;
  logic           opt_scan;
  logic           accept;

  // Result staging ahead of the output register.
  logic                res_valid;
  logic [VICTIM_W-1:0] res_victim;
  logic                res_from_free;
  logic                res_sel;

  // Output register and skid slot, so a new word can be taken while the
  // previous result still waits for the downstream side.
  logic                out_valid;
  logic [VICTIM_W-1:0] out_victim;
  logic                out_from_free;
  logic                out_sel;
  logic                skid_valid;
  logic [VICTIM_W-1:0] skid_victim;
  logic                skid_from_free;
  logic                skid_sel;

  // Reference RAM and read stage feeding the head of the chain.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [PAGE_W-1:0] ram_rdata;
  word_ctl_t         rd_ctl;
  logic [AW-1:0]     rd_pos;

  // Record request decode.
  logic          rec_we;
  logic [FW-1:0] rec_frame;

  // Chain taps: index 0 is the read stage, index FRAME_COUNT the tail.
  word_ctl_t         ch_ctl      [FRAME_COUNT+1];
  logic [PAGE_W-1:0] ch_page     [FRAME_COUNT+1];
  logic [AW-1:0]     ch_pos      [FRAME_COUNT+1];
  token_t            ch_tok      [FRAME_COUNT+1];
  logic [FW-1:0]     ch_best     [FRAME_COUNT+1];
  logic [AW-1:0]     ch_best_pos [FRAME_COUNT+1];

  assign accept = s_tvalid && s_tready;

  // Items are taken only while no scan is running and the skid slot is free.
  assign s_tready = (state == ST_IDLE) && !skid_valid;

  // The scan stops at the shorter of the programmed length and the store.
  assign len_ext    = EW'(seq_len);
  assign end_ptr    = (len_ext > EW'(SEQ_DEPTH)) ? FPW'(SEQ_DEPTH) : FPW'(len_ext);
  assign scan_empty = (fut_ptr >= end_ptr);
  assign free_full  = (free_cnt == FCW'(FRAME_COUNT));
  assign rd_last    = (FPW'(rd_cnt + FPW'(1)) == end_ptr);

  // An optimal select with entries left to look at launches the chain scan;
  // with nothing left every frame is unused again, which picks frame 0.
  assign opt_scan = accept && (req == REQ_SELECT) && free_full &&
                    (policy == POLICY_OPTIMAL) && !scan_empty;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (opt_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (ch_ctl[FRAME_COUNT].valid && ch_ctl[FRAME_COUNT].last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    res_valid     = 1'b0;
    res_victim    = '0;
    res_from_free = 1'b0;
    res_sel       = 1'b0;
    case (state)
      ST_IDLE: begin
        res_valid = accept && !opt_scan;
        if (req == REQ_SELECT) begin
          res_sel = 1'b1;
          if (!free_full) begin
            res_victim    = VICTIM_W'({{VICTIM_W{1'b0}}, free_cnt});
            res_from_free = 1'b1;
          end else if (policy == POLICY_FIFO) begin
            res_victim = VICTIM_W'({{VICTIM_W{1'b0}}, fifo_ptr});
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
      end
      ST_WAIT: begin
        res_valid  = ch_ctl[FRAME_COUNT].valid && ch_ctl[FRAME_COUNT].last;
        res_victim = VICTIM_W'({{VICTIM_W{1'b0}}, ch_best[FRAME_COUNT]});
        res_sel    = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes must arrive only while the block is idle, unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POLICY_FIFO;
      seq_len <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_POLICY:  policy  <= policy_t'(cfg_data[0]);
        CFG_SEQ_LEN: seq_len <= cfg_data[SEQ_LEN_W-1:0];
        default:     policy  <= policy;
      endcase
    end
  end

  // Free frames are handed out first; the FIFO pointer only moves once all
  // frames are in use. A restart touches only the future pointer, and a
  // record advances it up to the end of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_ptr <= '0;
      free_cnt <= '0;
      fut_ptr  <= '0;
    end else if (accept) begin
      case (req)
        REQ_RESTART: begin
          fut_ptr <= '0;
        end
        REQ_SELECT: begin
          if (!free_full) begin
            free_cnt <= FCW'(free_cnt + FCW'(1));
          end else if (policy == POLICY_FIFO) begin
            fifo_ptr <= (fifo_ptr == FW'(FRAME_COUNT - 1)) ? '0 : FW'(fifo_ptr + FW'(1));
          end
        end
        REQ_RECORD: begin
          if (fut_ptr < FPW'(SEQ_DEPTH)) begin
            fut_ptr <= FPW'(fut_ptr + FPW'(1));
          end
        end
        default: begin
          fut_ptr <= fut_ptr;
        end
      endcase
    end
  end

  // The read counter starts at the future pointer and walks to the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
    end else if (opt_scan) begin
      rd_cnt <= fut_ptr;
    end else if (rd_en) begin
      rd_cnt <= FPW'(rd_cnt + FPW'(1));
    end
  end

  // --------------------------------------------------------- reference RAM
  assign ram_we    = accept && (req == REQ_LOAD) && (IW'(in_ref_index) < IW'(SEQ_DEPTH));
  assign ram_waddr = AW'(in_ref_index);

  pvs_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (SEQ_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_page),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Framing lines up with the registered RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
    end else begin
      rd_ctl.valid <= rd_en;
      rd_ctl.first <= rd_en && (rd_cnt == fut_ptr);
      rd_ctl.last  <= rd_en && rd_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos <= rd_cnt[AW-1:0];
  end

  // ------------------------------------------------------------ cell chain
  // Each reference word steps one cell per cycle. The search token enters
  // empty at the head and is settled cell by cell as the last word passes.
  assign ch_ctl[0]      = rd_ctl;
  assign ch_page[0]     = ram_rdata;
  assign ch_pos[0]      = rd_pos;
  assign ch_tok[0]      = '0;
  assign ch_best[0]     = '0;
  assign ch_best_pos[0] = '0;

  assign rec_we    = accept && (req == REQ_RECORD) && (CW'(in_frame) < CW'(FRAME_COUNT));
  assign rec_frame = FW'(in_frame);

  for (genvar f = 0; f < FRAME_COUNT; f++) begin : g_cell
    pvs_cell #(
      .FW      (FW),
      .PW      (AW),
      .CELL_ID (f)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .page_we      (rec_we && (rec_frame == FW'(f))),
      .page_wdata   (in_page),
      .in_ctl       (ch_ctl[f]),
      .in_page      (ch_page[f]),
      .in_pos       (ch_pos[f]),
      .in_tok       (ch_tok[f]),
      .in_best      (ch_best[f]),
      .in_best_pos  (ch_best_pos[f]),
      .out_ctl      (ch_ctl[f+1]),
      .out_page     (ch_page[f+1]),
      .out_pos      (ch_pos[f+1]),
      .out_tok      (ch_tok[f+1]),
      .out_best     (ch_best[f+1]),
      .out_best_pos (ch_best_pos[f+1])
    );
  end

  // -------------------------------------------------------- output stage
  // When the output register frees up, a word parked in the skid slot moves
  // in first and a new result takes the skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_victim    <= skid_victim;
        out_from_free <= skid_from_free;
        out_sel       <= skid_sel;
        skid_victim    <= res_victim;
        skid_from_free <= res_from_free;
        skid_sel       <= res_sel;
      end else begin
        out_victim    <= res_victim;
        out_from_free <= res_from_free;
        out_sel       <= res_sel;
      end
    end else if (res_valid) begin
      skid_victim    <= res_victim;
      skid_from_free <= res_from_free;
      skid_sel       <= res_sel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_from_free, out_victim});
  assign m_tuser  = M_TUSER_W'(out_sel);

endmodule

/* dv/page_victim_selector_unit_tb.sv */
// ----------------------------------------------------------------------------
// page_victim_selector_unit_tb: self-checking bench for the victim selector
// Streams load, restart, select and record words into the block under random
// source gaps and sink stalls, predicts every result word with a behavioral
// copy of the FIFO and farthest-next-use policies, and checks each result
// word field by field in order.
// ----------------------------------------------------------------------------
module page_victim_selector_unit_tb;
  import pvs_pkg::*;

  localparam int FRAMES    = 8;
  localparam int DEPTH     = 1024;
  localparam int RAND_REQS = 580;
  localparam int MAX_SHOWN = 40;

  // One request word as the bench sees it, and one predicted result word.
  typedef struct packed {
    req_t                   kind;
    logic [REF_INDEX_W-1:0] ref_index;
    logic [PAGE_W-1:0]      page;
    logic [FRAME_W-1:0]     frame;
  } page_req_t;

  typedef struct packed {
    logic [VICTIM_W-1:0] victim;
    logic                victim_valid;
    logic                from_free;
  } victim_word_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic [S_TUSER_W-1:0]   s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [M_TUSER_W-1:0]   m_tuser;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  page_victim_selector_unit #(
    .FRAME_COUNT(FRAMES),
    .SEQ_DEPTH  (DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs. Far above the slowest legal run, in
  // which every word would wait out a full-depth scan plus both idle draws.
  initial begin
    #40_000_000;
    $display("page_victim_selector_unit_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor state. The reference pages are only ever read after the
  // stimulus has written them, so they need no reset value here.
  // --------------------------------------------------------------------------
  logic [PAGE_W-1:0]    ref_pages [DEPTH];
  logic [PAGE_W-1:0]    held_page [FRAMES];
  logic [VICTIM_W-1:0]  rr_ptr;
  int unsigned          fresh_frames;
  int unsigned          next_use_ptr;
  policy_t              mode;
  logic [SEQ_LEN_W-1:0] seq_len;

  victim_word_t victim_expect [$];
  page_req_t    pending_reqs [$];
  int unsigned  reqs_queued   = 0;
  int unsigned  reqs_taken    = 0;
  int unsigned  mismatch_count = 0;

  // Handshake flags seen at the last rising edge, used by both drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  // Idle ceilings per side; zero gives a stretch with no idling at all.
  int unsigned src_wait_max = 15;
  int unsigned snk_wait_max = 15;
  int unsigned src_wait     = 0;
  int unsigned snk_wait     = 0;

  function automatic void clear_model();
    for (int f = 0; f < FRAMES; f++) held_page[f] = '0;
    rr_ptr       = '0;
    fresh_frames = 0;
    next_use_ptr = 0;
    mode         = POLICY_FIFO;
    seq_len      = '0;
  endfunction

  // Belady choice: the lowest frame whose page does not come up again from
  // the future pointer on wins at once. Otherwise the frame whose first
  // upcoming use is farthest away wins, the lower frame on a tie. With the
  // pointer at or past the end of the string nothing is found and frame 0
  // falls out of the first test.
  function automatic logic [VICTIM_W-1:0] farthest_frame();
    int unsigned  stop;
    int unsigned  best_at;
    int unsigned  hit_at;
    int           f;
    int           j;
    logic [VICTIM_W-1:0] best;
    bit           have;
    bit           hit;
    stop    = (seq_len > DEPTH) ? DEPTH : seq_len;
    best    = '0;
    best_at = 0;
    have    = 1'b0;
    for (f = 0; f < FRAMES; f++) begin
      hit    = 1'b0;
      hit_at = 0;
      for (j = next_use_ptr; j < stop && !hit; j++) begin
        if (ref_pages[j] == held_page[f]) begin
          hit    = 1'b1;
          hit_at = j;
        end
      end
      if (!hit) return VICTIM_W'(f);
      if (!have || hit_at > best_at) begin
        have    = 1'b1;
        best_at = hit_at;
        best    = VICTIM_W'(f);
      end
    end
    return best;
  endfunction

  // Applies one accepted request word and returns the result word it owes.
  function automatic victim_word_t predict_victim(page_req_t r);
    victim_word_t w;
    w = '0;
    case (r.kind)
      REQ_LOAD: begin
        ref_pages[r.ref_index] = r.page;
      end
      REQ_RESTART: begin
        // Only the future pointer rewinds; free count, FIFO pointer and
        // frame pages are kept.
        next_use_ptr = 0;
      end
      REQ_SELECT: begin
        w.victim_valid = 1'b1;
        if (fresh_frames < FRAMES) begin
          w.victim  = VICTIM_W'(fresh_frames);
          w.from_free = 1'b1;
          fresh_frames++;
        end else if (mode == POLICY_FIFO) begin
          w.victim = rr_ptr;
          rr_ptr   = rr_ptr + 1'b1;
        end else begin
          w.victim = farthest_frame();
        end
      end
      REQ_RECORD: begin
        held_page[r.frame] = r.page;
        if (next_use_ptr < DEPTH) next_use_ptr++;
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned pick_wait(int unsigned top);
    return (top == 0) ? 0 : $urandom_range(top);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. A new word goes out at the falling edge after the
  // previous one was taken, once its drawn gap has run out. s_tvalid gets a
  // single assignment per step, so back-to-back words keep it high.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    page_req_t next_req;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      src_wait  = 0;
    end else if (!s_tvalid || in_taken) begin
      if (in_taken) src_wait = pick_wait(src_wait_max);
      if (src_wait == 0 && pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        // tdata, from bit 0: ref_index, page, frame, zero pad.
        s_tdata  <= {3'b000, next_req.frame, next_req.page, next_req.ref_index};
        // tuser: request kind.
        s_tuser  <= next_req.kind;
      end else begin
        s_tvalid <= 1'b0;
        if (src_wait > 0) src_wait--;
      end
    end
  end

  // Result sink: after each taken word it stalls for a fresh random count.
  always @(negedge clk) begin : result_sink
    if (rst) begin
      m_tready <= 1'b0;
      snk_wait  = 0;
    end else begin
      if (out_taken) snk_wait = pick_wait(snk_wait_max);
      if (snk_wait > 0) begin
        m_tready <= 1'b0;
        snk_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge it applies register writes to the predictor,
  // predicts every accepted request word, and checks every accepted result
  // word against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    page_req_t    got_req;
    victim_word_t want;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
      clear_model();
    end else begin
      in_taken  <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_POLICY:  mode    = policy_t'(cfg_data[0]);
          CFG_SEQ_LEN: seq_len = cfg_data;
        endcase
      end
      if (s_tvalid && s_tready) begin
        got_req.kind      = req_t'(s_tuser);
        got_req.ref_index = s_tdata[9:0];
        got_req.page      = s_tdata[25:10];
        got_req.frame     = s_tdata[28:26];
        victim_expect.push_back(predict_victim(got_req));
        reqs_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (victim_expect.size() == 0) begin
          report_mismatch($sformatf("result word %h/%h with nothing expected",
                                    m_tdata, m_tuser));
        end else begin
          want = victim_expect.pop_front();
          if (m_tdata[2:0] !== want.victim)
            report_mismatch($sformatf("victim %0d, expected %0d",
                                      m_tdata[2:0], want.victim));
          if (m_tuser[0] !== want.victim_valid)
            report_mismatch($sformatf("victim_valid %b, expected %b",
                                      m_tuser[0], want.victim_valid));
          if (m_tdata[3] !== want.from_free)
            report_mismatch($sformatf("from_free %b, expected %b",
                                      m_tdata[3], want.from_free));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_req(req_t kind, logic [REF_INDEX_W-1:0] idx,
                           logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
    page_req_t r;
    r.kind      = kind;
    r.ref_index = idx;
    r.page      = page;
    r.frame     = frame;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Pages come mostly from a small set so that frames and reference entries
  // match often; now and then a page from anywhere in the range, or all ones.
  function automatic logic [PAGE_W-1:0] pool_page();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return PAGE_W'($urandom_range(11));
    if (roll < 95) return PAGE_W'($urandom());
    return '1;
  endfunction

  // Register writes happen only with the block idle. Every request owes one
  // result word, so the block is idle once all words were taken and all
  // results have come back; the short pause covers the output register.
  task automatic drain();
    while (reqs_taken != reqs_queued || victim_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Settings the first random phases must visit: empty string, a length
  // beyond the store depth, the full depth in both modes, a single entry.
  policy_t     forced_mode [5] = '{POLICY_OPTIMAL, POLICY_OPTIMAL, POLICY_OPTIMAL,
                                   POLICY_FIFO, POLICY_OPTIMAL};
  int unsigned forced_len  [5] = '{0, 2047, 1024, 1024, 1};

  initial begin : stimulus
    int          phase;
    int          k;
    int unsigned count;
    int unsigned shape;
    int unsigned roll;
    int unsigned len;
    int unsigned rand_start;
    policy_t     pol;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, FIFO mode with an empty string. The loads put a short
    // string at the head of the store and walk every index and page bit.
    queue_req(REQ_LOAD, 10'd0,     16'h0001, 3'd0);
    queue_req(REQ_LOAD, 10'd1,     16'h0002, 3'd0);
    queue_req(REQ_LOAD, 10'd2,     16'h0001, 3'd0);
    queue_req(REQ_LOAD, 10'd3,     16'hFFFF, 3'd0);
    queue_req(REQ_LOAD, 10'd1023,  16'h5555, 3'd7);
    queue_req(REQ_LOAD, 10'h2AA,   16'hAAAA, 3'd5);
    queue_req(REQ_LOAD, 10'h155,   16'h0000, 3'd2);
    // Eight selects drain the never-used frames, two more go round robin.
    for (k = 0; k < 10; k++) queue_req(REQ_SELECT, '0, '0, '0);
    // Fill every frame; the pointer ends up past the short string.
    queue_req(REQ_RECORD, '0, 16'h0001, 3'd0);
    queue_req(REQ_RECORD, '0, 16'h0002, 3'd1);
    for (k = 2; k < FRAMES; k++) queue_req(REQ_RECORD, '0, 16'hFFFF, 3'(k));
    drain();

    write_reg(CFG_POLICY,  CFG_DATA_W'(POLICY_OPTIMAL));
    write_reg(CFG_SEQ_LEN, 11'd4);
    @(posedge clk);
    // Pointer past the end: nothing is found and frame 0 is chosen.
    queue_req(REQ_SELECT,  '0, '0, '0);
    // A restart keeps the frames full; every page recurs, farthest tie.
    queue_req(REQ_RESTART, '0, '0, '0);
    queue_req(REQ_SELECT,  '0, '0, '0);
    // Frame 5 gets a page that never recurs, so it is chosen.
    queue_req(REQ_RECORD,  '0, 16'h1234, 3'd5);
    queue_req(REQ_SELECT,  '0, '0, '0);
    drain();

    // Fill the whole reference store back to back with no idling, so that
    // any later scan, up to the full depth, reads written entries only.
    src_wait_max = 0;
    snk_wait_max = 0;
    @(posedge clk);
    for (k = 0; k < DEPTH; k++) queue_req(REQ_LOAD, 10'(k), pool_page(), 3'($urandom()));
    drain();

    // Random phases, each with its own register setting and idle profile.
    rand_start = reqs_queued;
    phase      = 0;
    while (reqs_queued - rand_start < RAND_REQS) begin
      drain();
      if (phase < 5) begin
        pol = forced_mode[phase];
        len = forced_len[phase];
      end else begin
        pol  = ($urandom_range(9) < 7) ? POLICY_OPTIMAL : POLICY_FIFO;
        roll = $urandom_range(99);
        if (roll < 70)      len = $urandom_range(40);
        else if (roll < 88) len = $urandom_range(300);
        else                len = $urandom_range(2047, 1024);
      end
      phase++;
      src_wait_max = ($urandom_range(3) == 0) ? 0 : 15;
      snk_wait_max = ($urandom_range(3) == 0) ? 0 : 15;
      // The policy register only keeps bit 0; the rest is random filler.
      write_reg(CFG_POLICY,  {10'($urandom()), pol});
      write_reg(CFG_SEQ_LEN, CFG_DATA_W'(len));
      @(posedge clk);

      shape = $urandom_range(2);
      count = $urandom_range(40, 12);
      if (shape != 2) begin
        // Replacement loop: rewind, then select a frame and place a page,
        // with a reference entry rewritten now and then.
        queue_req(REQ_RESTART, 10'($urandom()), 16'($urandom()), 3'($urandom()));
        for (k = 0; k < count; k++) begin
          queue_req(REQ_SELECT, 10'($urandom()), 16'($urandom()), 3'($urandom()));
          queue_req(REQ_RECORD, 10'($urandom()), pool_page(), 3'($urandom()));
          if ($urandom_range(9) == 0)
            queue_req(REQ_LOAD, 10'($urandom()), pool_page(), 3'($urandom()));
        end
      end else begin
        // Loose mix of all request kinds, including stray restarts.
        for (k = 0; k < 2 * count; k++) begin
          roll = $urandom_range(99);
          if (roll < 10)
            queue_req(REQ_LOAD, 10'($urandom()), pool_page(), 3'($urandom()));
          else if (roll < 18)
            queue_req(REQ_RESTART, 10'($urandom()), 16'($urandom()), 3'($urandom()));
          else if (roll < 58)
            queue_req(REQ_SELECT, 10'($urandom()), 16'($urandom()), 3'($urandom()));
          else
            queue_req(REQ_RECORD, 10'($urandom()), pool_page(), 3'($urandom()));
        end
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("page_victim_selector_unit_tb: PASS");
    end else begin
      $display("page_victim_selector_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
